[hw/rtl/ida_pkg.sv]
// shared types, opcodes and helpers for the interval alu
`timescale 1ns / 1ps
package ida_pkg;
  typedef enum logic [4:0] {
    K_JOIN = 5'd0, K_MEET = 5'd1, K_WIDEN = 5'd2, K_NEG = 5'd3, K_ADD = 5'd4,
    K_SUB = 5'd5, K_MUL = 5'd6, K_LE = 5'd7, K_LT = 5'd8, K_GE = 5'd9,
    K_GT = 5'd10, K_EQ = 5'd11, K_NE = 5'd12, K_CONT = 5'd13, K_SINGLE = 5'd14,
    K_EQUAL = 5'd15, K_FITS = 5'd16
  } kind_t;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic emp;
    logic linf;
    logic hinf;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
  } ivl_t;

  // request after normalisation in stage one
  typedef struct packed {
    logic [4:0] kind;
    ivl_t a;
    ivl_t b;
    logic signed [63:0] s;
  } req_t;

  typedef struct packed {
    ivl_t r;
    logic q;
  } res_t;

  function automatic ivl_t mk_bot();
    ivl_t r;
    r = '0;
    r.emp = 1'b1;
    return r;
  endfunction

  function automatic ivl_t mk_top();
    ivl_t r;
    r = '0;
    r.linf = 1'b1;
    r.hinf = 1'b1;
    return r;
  endfunction

  function automatic ivl_t load(logic e, logic li, logic hn,
                                logic signed [63:0] lo, logic signed [63:0] hi);
    ivl_t r;
    r.emp = 1'b0;
    r.linf = li;
    r.hinf = hn;
    r.lo = li ? 64'sd0 : lo;
    r.hi = hn ? 64'sd0 : hi;
    if (e || (!li && !hn && lo > hi)) r = mk_bot();
    return r;
  endfunction

  function automatic ivl_t meet(ivl_t a, ivl_t b);
    ivl_t r;
    r = '0;
    if (a.linf && b.linf) r.linf = 1'b1;
    else if (a.linf) r.lo = b.lo;
    else if (b.linf) r.lo = a.lo;
    else r.lo = (a.lo > b.lo) ? a.lo : b.lo;
    if (a.hinf && b.hinf) r.hinf = 1'b1;
    else if (a.hinf) r.hi = b.hi;
    else if (b.hinf) r.hi = a.hi;
    else r.hi = (a.hi < b.hi) ? a.hi : b.hi;
    if (a.emp || b.emp || (!r.linf && !r.hinf && r.lo > r.hi)) r = mk_bot();
    return r;
  endfunction
endpackage

[hw/rtl/ida_mul.sv]
// signed 64x64 product with overflow flag, four 32-bit partial products over two stages
`timescale 1ns / 1ps
module ida_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] x,
  input  logic signed [63:0] y,
  output logic signed [63:0] p,
  output logic               ovf
);
  logic [63:0] ux, uy;
  logic        neg;
  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  logic        neg_r;
  logic [65:0] mid;
  logic [63:0] lw;
  logic [65:0] hw;
  logic signed [63:0] p_r;
  logic        ovf_r;

  assign neg = x[63] ^ y[63];
  assign ux  = x[63] ? (64'd0 - x) : x;
  assign uy  = y[63] ? (64'd0 - y) : y;

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= ux[31:0] * uy[31:0];
      p01_r <= ux[31:0] * uy[63:32];
      p10_r <= ux[63:32] * uy[31:0];
      p11_r <= ux[63:32] * uy[63:32];
      neg_r <= neg;
    end
  end

  always_comb begin
    mid = {34'd0, p00_r[63:32]} + {34'd0, p01_r[31:0]} + {34'd0, p10_r[31:0]};
    lw  = {mid[31:0], p00_r[31:0]};
    hw  = {2'd0, p11_r} + {34'd0, p01_r[63:32]} + {34'd0, p10_r[63:32]}
        + {32'd0, mid[65:32]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r <= (hw != 66'd0) || (lw > (neg_r ? 64'h8000_0000_0000_0000
                                             : 64'h7FFF_FFFF_FFFF_FFFF));
      p_r   <= neg_r ? (64'd0 - lw) : lw;
    end
  end

  assign p   = p_r;
  assign ovf = ovf_r;
endmodule

[hw/rtl/ida_logic.sv]
// non-multiply operations, evaluated in one stage from a normalised request
`timescale 1ns / 1ps
module ida_logic (
  input  ida_pkg::req_t rq,
  output ida_pkg::res_t rs
);
  ida_pkg::ivl_t a, b, nb, t, r;
  logic signed [63:0] s, sl, sh, fmax;
  logic q;
  logic ofl, ofh;
  logic signed [63:0] sumlo, sumhi;
  logic [5:0] bits;

  always_comb begin
    a = rq.a;
    b = rq.b;
    s = rq.s;
    r = '0;
    q = 1'b0;
    t = '0;
    // negated b for subtract
    nb = '0;
    if (b.emp) nb = b;
    else if ((!b.hinf && b.hi == ida_pkg::S64_MIN) ||
             (!b.linf && b.lo == ida_pkg::S64_MIN)) nb = ida_pkg::mk_top();
    else begin
      nb.linf = b.hinf;
      nb.hinf = b.linf;
      nb.lo = b.hinf ? 64'sd0 : -b.hi;
      nb.hi = b.linf ? 64'sd0 : -b.lo;
    end
    if (rq.kind == ida_pkg::K_SUB) t = nb;
    else t = b;
    sumlo = a.lo + t.lo;
    sumhi = a.hi + t.hi;
    ofl = (a.lo[63] == t.lo[63]) && (sumlo[63] != a.lo[63]);
    ofh = (a.hi[63] == t.hi[63]) && (sumhi[63] != a.hi[63]);
    sl = s - 64'sd1;
    sh = s + 64'sd1;
    bits = s[5:0] - 6'd1;
    fmax = (s == 64'sd64) ? ida_pkg::S64_MAX : ((64'sd1 <<< bits) - 64'sd1);
    case (rq.kind)
      ida_pkg::K_JOIN: begin
        if (a.emp) r = b;
        else if (b.emp) r = a;
        else begin
          r.linf = a.linf || b.linf;
          r.hinf = a.hinf || b.hinf;
          r.lo = r.linf ? 64'sd0 : ((a.lo < b.lo) ? a.lo : b.lo);
          r.hi = r.hinf ? 64'sd0 : ((a.hi > b.hi) ? a.hi : b.hi);
        end
      end
      ida_pkg::K_MEET: r = ida_pkg::meet(a, b);
      ida_pkg::K_WIDEN: begin
        if (a.emp || b.emp) r = b;
        else begin
          r.linf = b.linf || (!a.linf && b.lo < a.lo);
          r.hinf = b.hinf || (!a.hinf && b.hi > a.hi);
          r.lo = r.linf ? 64'sd0 : b.lo;
          r.hi = r.hinf ? 64'sd0 : b.hi;
        end
      end
      ida_pkg::K_NEG: begin
        if (a.emp) r = a;
        else if ((!a.hinf && a.hi == ida_pkg::S64_MIN) ||
                 (!a.linf && a.lo == ida_pkg::S64_MIN)) r = ida_pkg::mk_top();
        else begin
          r.linf = a.hinf;
          r.hinf = a.linf;
          r.lo = a.hinf ? 64'sd0 : -a.hi;
          r.hi = a.linf ? 64'sd0 : -a.lo;
        end
      end
      ida_pkg::K_ADD, ida_pkg::K_SUB: begin
        if (a.emp || t.emp) r = ida_pkg::mk_bot();
        else if ((!(a.linf || t.linf) && ofl) || (!(a.hinf || t.hinf) && ofh))
          r = ida_pkg::mk_top();
        else begin
          r.linf = a.linf || t.linf;
          r.hinf = a.hinf || t.hinf;
          r.lo = r.linf ? 64'sd0 : sumlo;
          r.hi = r.hinf ? 64'sd0 : sumhi;
        end
      end
      ida_pkg::K_LE: r = ida_pkg::meet(a, '{1'b0, 1'b1, 1'b0, 64'sd0, s});
      ida_pkg::K_LT: r = (s == ida_pkg::S64_MIN) ? ida_pkg::mk_bot()
                       : ida_pkg::meet(a, '{1'b0, 1'b1, 1'b0, 64'sd0, sl});
      ida_pkg::K_GE: r = ida_pkg::meet(a, '{1'b0, 1'b0, 1'b1, s, 64'sd0});
      ida_pkg::K_GT: r = (s == ida_pkg::S64_MAX) ? ida_pkg::mk_bot()
                       : ida_pkg::meet(a, '{1'b0, 1'b0, 1'b1, sh, 64'sd0});
      ida_pkg::K_EQ: r = ida_pkg::meet(a, '{1'b0, 1'b0, 1'b0, s, s});
      ida_pkg::K_NE: begin
        if (a.emp) r = a;
        else if (!a.linf && a.lo == s) begin
          if (!a.hinf && a.lo == a.hi) r = ida_pkg::mk_bot();
          else r = ida_pkg::meet(a, '{1'b0, 1'b0, 1'b1,
                     (s == ida_pkg::S64_MAX) ? s : sh, 64'sd0});
        end else if (!a.hinf && a.hi == s)
          r = ida_pkg::meet(a, '{1'b0, 1'b1, 1'b0, 64'sd0,
                (s == ida_pkg::S64_MIN) ? s : sl});
        else r = a;
      end
      ida_pkg::K_CONT:
        q = !a.emp && (a.linf || s >= a.lo) && (a.hinf || s <= a.hi);
      ida_pkg::K_SINGLE: q = !a.emp && !a.linf && !a.hinf && a.lo == a.hi;
      ida_pkg::K_EQUAL: begin
        if (a.emp || b.emp) q = (a.emp == b.emp);
        else q = (a.linf == b.linf) && (a.hinf == b.hinf) &&
                 (a.linf || a.lo == b.lo) && (a.hinf || a.hi == b.hi);
      end
      ida_pkg::K_FITS: begin
        if (a.emp) q = 1'b1;
        else if (a.linf || a.hinf || s < 64'sd1 || s > 64'sd64) q = 1'b0;
        else q = (a.lo >= (-fmax - 64'sd1)) && (a.hi <= fmax);
      end
      default: r = '0;
    endcase
    if (r.emp) r = ida_pkg::mk_bot();
    rs.r = r;
    rs.q = q;
  end
endmodule

[hw/rtl/interval_domain_alu_core.sv]
// Interval alu over signed 64-bit bounds: one request accepted every cycle while not
// stalled. Four register stages (normalise, partial products, product fold, min/max and
// select); a result is on the outputs once it reaches the last stage and is held there
// until taken. The depth is set by the 64-bit multiplier split into 32-bit partial products.
// A stall freezes the whole pipeline; the output register holds.
`timescale 1ns / 1ps
module interval_domain_alu_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_kind,
  input  logic               in_a_empty,
  input  logic               in_a_lo_inf,
  input  logic               in_a_hi_inf,
  input  logic signed [63:0] in_a_lo,
  input  logic signed [63:0] in_a_hi,
  input  logic               in_b_empty,
  input  logic               in_b_lo_inf,
  input  logic               in_b_hi_inf,
  input  logic signed [63:0] in_b_lo,
  input  logic signed [63:0] in_b_hi,
  input  logic signed [63:0] in_scalar,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_r_empty,
  output logic               out_r_lo_inf,
  output logic               out_r_hi_inf,
  output logic signed [63:0] out_r_lo,
  output logic signed [63:0] out_r_hi,
  output logic               out_query_true
);
  logic en;
  logic [3:0] v_r;
  ida_pkg::req_t rq1_r, rq2_r, rq3_r;
  ida_pkg::res_t lg, lg2_r, lg3_r, res_r, res_nxt;
  logic signed [63:0] p0, p1, p2, p3, mn, mx;
  logic o0, o1, o2, o3;

  // advance whenever the output is free or will be taken
  assign en = !(v_r[3] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rq1_r.kind <= in_kind;
      rq1_r.a <= ida_pkg::load(in_a_empty, in_a_lo_inf, in_a_hi_inf, in_a_lo, in_a_hi);
      rq1_r.b <= ida_pkg::load(in_b_empty, in_b_lo_inf, in_b_hi_inf, in_b_lo, in_b_hi);
      rq1_r.s <= in_scalar;
      rq2_r <= rq1_r;
      rq3_r <= rq2_r;
      lg2_r <= lg;
      lg3_r <= lg2_r;
      res_r <= res_nxt;
    end
  end

  ida_logic u_logic (.rq(rq1_r), .rs(lg));

  ida_mul u_m0 (.clk(clk), .en(en), .x(rq1_r.a.lo), .y(rq1_r.b.lo), .p(p0), .ovf(o0));
  ida_mul u_m1 (.clk(clk), .en(en), .x(rq1_r.a.lo), .y(rq1_r.b.hi), .p(p1), .ovf(o1));
  ida_mul u_m2 (.clk(clk), .en(en), .x(rq1_r.a.hi), .y(rq1_r.b.lo), .p(p2), .ovf(o2));
  ida_mul u_m3 (.clk(clk), .en(en), .x(rq1_r.a.hi), .y(rq1_r.b.hi), .p(p3), .ovf(o3));

  always_comb begin
    mn = p0;
    mx = p0;
    if (p1 < mn) mn = p1;
    if (p1 > mx) mx = p1;
    if (p2 < mn) mn = p2;
    if (p2 > mx) mx = p2;
    if (p3 < mn) mn = p3;
    if (p3 > mx) mx = p3;
    res_nxt = lg3_r;
    if (rq3_r.kind == ida_pkg::K_MUL) begin
      res_nxt = '0;
      if (rq3_r.a.emp || rq3_r.b.emp) res_nxt.r = ida_pkg::mk_bot();
      else if ((!rq3_r.a.linf && !rq3_r.a.hinf && rq3_r.a.lo == 64'sd0 &&
                rq3_r.a.hi == 64'sd0) ||
               (!rq3_r.b.linf && !rq3_r.b.hinf && rq3_r.b.lo == 64'sd0 &&
                rq3_r.b.hi == 64'sd0)) res_nxt.r = '0;
      else if (rq3_r.a.linf || rq3_r.a.hinf || rq3_r.b.linf || rq3_r.b.hinf ||
               o0 || o1 || o2 || o3) res_nxt.r = ida_pkg::mk_top();
      else begin
        res_nxt.r.lo = mn;
        res_nxt.r.hi = mx;
      end
    end
  end

  assign out_valid      = v_r[3];
  assign out_r_empty    = res_r.r.emp;
  assign out_r_lo_inf   = res_r.r.linf;
  assign out_r_hi_inf   = res_r.r.hinf;
  assign out_r_lo       = res_r.r.lo;
  assign out_r_hi       = res_r.r.hi;
  assign out_query_true = res_r.q;
endmodule
